// File: hw/rtl/pcsm_pkg.sv
// Package: shared types, codes and defaults for the p-code stack machine.
`timescale 1ns / 1ps

package pcsm_pkg;

	// Default memory depths (powers of two)
	localparam int CODE_DEPTH_DEF  = 512;
	localparam int STACK_DEPTH_DEF = 1024;

	// Commands
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_EXEC  = 2'd2;

	// Opcodes
	localparam logic [3:0] OP_LIT   = 4'd0;
	localparam logic [3:0] OP_OPR   = 4'd1;
	localparam logic [3:0] OP_LOD   = 4'd2;
	localparam logic [3:0] OP_STO   = 4'd3;
	localparam logic [3:0] OP_CAL   = 4'd4;
	localparam logic [3:0] OP_INT   = 4'd5;
	localparam logic [3:0] OP_JMP   = 4'd6;
	localparam logic [3:0] OP_JPC   = 4'd7;
	localparam logic [3:0] OP_READ  = 4'd8;
	localparam logic [3:0] OP_WRITE = 4'd9;

	// Operator numbers of opr
	localparam logic [4:0] OPR_RET   = 5'd0;
	localparam logic [4:0] OPR_NEG   = 5'd1;
	localparam logic [4:0] OPR_ADD   = 5'd2;
	localparam logic [4:0] OPR_SUB   = 5'd3;
	localparam logic [4:0] OPR_MUL   = 5'd4;
	localparam logic [4:0] OPR_DIV   = 5'd5;
	localparam logic [4:0] OPR_ODD   = 5'd6;
	localparam logic [4:0] OPR_EQ    = 5'd8;
	localparam logic [4:0] OPR_NE    = 5'd9;
	localparam logic [4:0] OPR_LT    = 5'd10;
	localparam logic [4:0] OPR_GE    = 5'd11;
	localparam logic [4:0] OPR_GT    = 5'd12;
	localparam logic [4:0] OPR_LE    = 5'd13;
	localparam logic [4:0] OPR_NL    = 5'd14;
	localparam logic [4:0] OPR_PRINT = 5'd15;
	localparam logic [4:0] OPR_REAL  = 5'd16;
	localparam logic [4:0] OPR_OR    = 5'd17;
	localparam logic [4:0] OPR_NONE  = 5'd31;

	// Result events
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_STORE   = 3'd1;
	localparam logic [2:0] EV_WRITE   = 3'd2;
	localparam logic [2:0] EV_PRINT   = 3'd3;
	localparam logic [2:0] EV_NEWLINE = 3'd4;
	localparam logic [2:0] EV_REAL    = 3'd5;
	localparam logic [2:0] EV_HALTED  = 3'd6;
	localparam logic [2:0] EV_ERROR   = 3'd7;

	typedef struct packed {
		logic [1:0]  command;
		logic [8:0]  code_addr;
		logic [3:0]  instr_op;
		logic [2:0]  instr_level;
		logic signed [31:0] instr_arg;
		logic signed [31:0] read_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic signed [31:0] value;
		logic [8:0]  pc;
	} out_item_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [2:0]  lev;
		logic [31:0] arg;
	} code_word_t;

	// Divider request and response
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

// File: hw/rtl/pcsm_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module pcsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/pcsm_div.sv
// Radix-2 restoring signed divider, truncating toward zero, one bit per cycle.
`timescale 1ns / 1ps

module pcsm_div
	import pcsm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	// Trial subtract of the shifted remainder
	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: operands as magnitudes, sign applied at the end
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[31] ^ req.divisor[31];
			rem_q <= '0;
			quo_q <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
			dsr_q <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

// File: hw/rtl/pcode_stack_machine.sv
// Top level: p-code stack machine sequencer around code and stack memories.
`timescale 1ns / 1ps

// One item is taken at a time; the sequencer reads and writes the code and
// stack RAMs (one write and one registered read port each) and returns one
// result per item through an output register, so the next item is taken while
// a result waits. Load, halted execute and unknown commands go straight to the
// result; start makes three stack clears; lod, sto, cal, read and write walk
// the static links on the stack read port, one hop per level; cal makes three
// frame writes; divide waits for the bit-serial divider.
// Both depths must be powers of two; addresses wrap by truncation.

module pcode_stack_machine
	import pcsm_pkg::*;
#(
	parameter int CODE_DEPTH  = CODE_DEPTH_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	localparam int CW = $clog2(CODE_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_FETCH = 4'd2;
	localparam logic [3:0] S_WALK  = 4'd3;
	localparam logic [3:0] S_WALKW = 4'd4;
	localparam logic [3:0] S_RDA   = 4'd5;
	localparam logic [3:0] S_RDB   = 4'd6;
	localparam logic [3:0] S_EXEC  = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_CALW  = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]    state_q;
	logic [CW-1:0] pc_q;
	logic [SW-1:0] base_q;
	logic [SW-1:0] top_q;
	logic          halted_q;
	logic          exec_q;
	logic [3:0]    op_q;
	logic [31:0]   arg_q;
	logic [31:0]   rdv_q;
	logic [SW-1:0] b_q;
	logic [2:0]    cnt_q;
	logic [SW-1:0] a_q;
	logic [31:0]   ya_q;
	logic [1:0]    ccnt_q;
	logic [2:0]    ev_q;
	logic [31:0]   val_q;
	logic          rsp_valid_q;
	out_item_t     rsp_q;

	// Memory ports
	logic          code_we;
	logic [CW-1:0] code_waddr;
	code_word_t    code_wdata;
	logic          code_re;
	logic [$bits(code_word_t)-1:0] code_rbits;
	code_word_t    code_rd;
	logic          stk_we;
	logic [SW-1:0] stk_waddr;
	logic [31:0]   stk_wdata;
	logic          stk_re;
	logic [SW-1:0] stk_raddr;
	logic [31:0]   stk_rd;

	div_req_t      div_req;
	div_rsp_t      div_rsp;

	logic          accept;
	logic          out_free;
	logic [31:0]   caddr_ext;
	logic [31:0]   pc_ext;
	logic [SW-1:0] top_p1;
	logic [SW-1:0] top_m1;
	logic [SW-1:0] ccnt_ext;
	logic [4:0]    opr_code;
	logic [31:0]   yb;
	logic [31:0]   alu_r;
	logic [31:0]   prod;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign caddr_ext = 32'(req.code_addr);
	assign pc_ext    = 32'(pc_q);
	assign top_p1    = top_q + SW'(1);
	assign top_m1    = top_q - SW'(1);
	assign ccnt_ext  = SW'(ccnt_q);
	assign code_rd   = code_word_t'(code_rbits);
	assign yb        = stk_rd;
	assign opr_code  = (arg_q[31:5] == '0) ? arg_q[4:0] : OPR_NONE;
	assign prod      = yb * ya_q;

	// Binary operators, x is the entry below the top, y the top
	always_comb begin
		case (opr_code)
			OPR_ADD: alu_r = yb + ya_q;
			OPR_SUB: alu_r = yb - ya_q;
			OPR_MUL: alu_r = prod;
			OPR_EQ:  alu_r = 32'(yb == ya_q);
			OPR_NE:  alu_r = 32'(yb != ya_q);
			OPR_LT:  alu_r = 32'($signed(yb) < $signed(ya_q));
			OPR_GE:  alu_r = 32'($signed(yb) >= $signed(ya_q));
			OPR_GT:  alu_r = 32'($signed(yb) > $signed(ya_q));
			OPR_LE:  alu_r = 32'($signed(yb) <= $signed(ya_q));
			default: alu_r = '0;
		endcase
	end

	// Code memory: written by load, read at the pc on execute
	assign code_we        = accept && (req.command == CMD_LOAD);
	assign code_waddr     = caddr_ext[CW-1:0];
	assign code_wdata.op  = req.instr_op;
	assign code_wdata.lev = req.instr_level;
	assign code_wdata.arg = req.instr_arg;
	assign code_re        = accept && (req.command == CMD_EXEC) && !halted_q;

	// Stack memory port control per state
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = top_q;
		stk_wdata = '0;
		stk_re    = 1'b0;
		stk_raddr = top_q;
		div_req.start    = 1'b0;
		div_req.dividend = yb;
		div_req.divisor  = ya_q;
		unique case (state_q)
			S_CLR: begin
				stk_we    = 1'b1;
				stk_waddr = SW'(1) + ccnt_ext;
			end
			S_FETCH: begin
				if (code_rd.op == OP_LIT) begin
					stk_we    = 1'b1;
					stk_waddr = top_p1;
					stk_wdata = code_rd.arg;
				end
			end
			S_WALK: begin
				stk_re    = (cnt_q != '0);
				stk_raddr = b_q;
			end
			S_RDA: begin
				stk_re = 1'b1;
				if (op_q == OP_LOD || op_q == OP_WRITE) begin
					stk_raddr = a_q;
				end else if (op_q == OP_OPR && opr_code == OPR_RET) begin
					stk_raddr = base_q + SW'(2);
				end
			end
			S_RDB: begin
				stk_re = 1'b1;
				if (opr_code == OPR_OR) begin
					stk_raddr = top_p1;
				end else if (opr_code == OPR_RET) begin
					stk_raddr = base_q + SW'(1);
				end else begin
					stk_raddr = top_m1;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_LOD: begin
						stk_we    = 1'b1;
						stk_waddr = top_p1;
						stk_wdata = ya_q;
					end
					OP_STO: begin
						stk_we    = 1'b1;
						stk_waddr = a_q;
						stk_wdata = ya_q;
					end
					OP_READ: begin
						stk_we    = 1'b1;
						stk_waddr = a_q;
						stk_wdata = rdv_q;
					end
					OP_OPR: begin
						case (opr_code)
							OPR_NEG: begin
								stk_we    = 1'b1;
								stk_wdata = 32'd0 - ya_q;
							end
							OPR_ODD: begin
								stk_we    = 1'b1;
								stk_wdata = ya_q & 32'd1;
							end
							OPR_OR: begin
								stk_we    = 1'b1;
								stk_wdata = 32'((ya_q != '0) || (yb != '0));
							end
							OPR_ADD, OPR_SUB, OPR_MUL, OPR_EQ, OPR_NE,
							OPR_LT, OPR_GE, OPR_GT, OPR_LE: begin
								stk_we    = 1'b1;
								stk_waddr = top_m1;
								stk_wdata = alu_r;
							end
							OPR_DIV: begin
								// zero divisor writes 0, else start divider
								stk_we        = (ya_q == '0);
								stk_waddr     = top_m1;
								div_req.start = (ya_q != '0);
							end
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			S_DIV: begin
				stk_we    = div_rsp.done;
				stk_waddr = top_m1;
				stk_wdata = div_rsp.quotient;
			end
			S_CALW: begin
				stk_we    = 1'b1;
				stk_waddr = top_p1 + ccnt_ext;
				case (ccnt_q)
					2'd0:    stk_wdata = 32'(b_q);
					2'd1:    stk_wdata = 32'(base_q);
					default: stk_wdata = 32'(pc_q);
				endcase
			end
			default: ;
		endcase
	end

	// Sequencer and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			base_q      <= SW'(1);
			top_q       <= '0;
			halted_q    <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ev_q   <= EV_NONE;
						val_q  <= '0;
						exec_q <= 1'b0;
						rdv_q  <= req.read_value;
						ccnt_q <= '0;
						state_q <= S_DONE;
						if (req.command == CMD_START) begin
							top_q    <= '0;
							base_q   <= SW'(1);
							pc_q     <= '0;
							halted_q <= 1'b0;
							state_q  <= S_CLR;
						end else if (req.command == CMD_EXEC) begin
							if (halted_q) begin
								ev_q <= EV_HALTED;
							end else begin
								exec_q  <= 1'b1;
								state_q <= S_FETCH;
							end
						end
					end
				end
				S_CLR: begin
					ccnt_q <= ccnt_q + 2'd1;
					if (ccnt_q == 2'd2) begin
						state_q <= S_DONE;
					end
				end
				S_FETCH: begin
					op_q  <= code_rd.op;
					arg_q <= code_rd.arg;
					pc_q  <= pc_q + CW'(1);
					b_q   <= base_q;
					cnt_q <= code_rd.lev;
					state_q <= S_DONE;
					case (code_rd.op)
						OP_LIT: top_q <= top_p1;
						OP_INT: top_q <= top_q + code_rd.arg[SW-1:0];
						OP_JMP: pc_q <= code_rd.arg[CW-1:0];
						OP_OPR, OP_JPC: state_q <= S_RDA;
						OP_LOD, OP_STO, OP_CAL, OP_READ, OP_WRITE: state_q <= S_WALK;
						default: ;
					endcase
				end
				S_WALK: begin
					if (cnt_q != '0) begin
						state_q <= S_WALKW;
					end else begin
						a_q <= b_q + arg_q[SW-1:0];
						if (op_q == OP_CAL) begin
							ccnt_q  <= '0;
							state_q <= S_CALW;
						end else if (op_q == OP_READ) begin
							state_q <= S_EXEC;
						end else begin
							state_q <= S_RDA;
						end
					end
				end
				S_WALKW: begin
					b_q     <= stk_rd[SW-1:0];
					cnt_q   <= cnt_q - 3'd1;
					state_q <= S_WALK;
				end
				S_RDA: begin
					state_q <= S_RDB;
				end
				S_RDB: begin
					ya_q    <= stk_rd;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (op_q)
						OP_LOD: top_q <= top_p1;
						OP_STO: begin
							top_q <= top_m1;
							ev_q  <= EV_STORE;
							val_q <= ya_q;
						end
						OP_WRITE: begin
							ev_q  <= EV_WRITE;
							val_q <= ya_q;
						end
						OP_JPC: begin
							if (ya_q == '0) begin
								pc_q <= arg_q[CW-1:0];
							end
						end
						OP_OPR: begin
							case (opr_code)
								OPR_RET: begin
									top_q  <= base_q - SW'(1);
									pc_q   <= ya_q[CW-1:0];
									base_q <= yb[SW-1:0];
								end
								OPR_NL: ev_q <= EV_NEWLINE;
								OPR_PRINT, OPR_REAL: begin
									ev_q  <= (opr_code == OPR_PRINT) ? EV_PRINT : EV_REAL;
									val_q <= ya_q;
									top_q <= top_m1;
								end
								OPR_OR, OPR_ADD, OPR_SUB, OPR_MUL, OPR_EQ, OPR_NE,
								OPR_LT, OPR_GE, OPR_GT, OPR_LE: top_q <= top_m1;
								OPR_DIV: begin
									if (ya_q == '0) begin
										ev_q  <= EV_ERROR;
										top_q <= top_m1;
									end else begin
										state_q <= S_DIV;
									end
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				S_DIV: begin
					if (div_rsp.done) begin
						top_q   <= top_m1;
						state_q <= S_DONE;
					end
				end
				S_CALW: begin
					ccnt_q <= ccnt_q + 2'd1;
					if (ccnt_q == 2'd2) begin
						base_q  <= top_p1;
						pc_q    <= arg_q[CW-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Halt check on the final pc, then transfer the result
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (exec_q && pc_q == '0) begin
							halted_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_q.event_res <= (exec_q && pc_q == '0 && ev_q == EV_NONE) ? EV_HALTED : ev_q;
			rsp_q.value     <= val_q;
			rsp_q.pc        <= pc_ext[8:0];
		end
	end

	pcsm_ram #(
		.WIDTH($bits(code_word_t)),
		.DEPTH(CODE_DEPTH)
	) u_code_ram (
		.clk   (clk),
		.we    (code_we),
		.waddr (code_waddr),
		.wdata (code_wdata),
		.re    (code_re),
		.raddr (pc_q),
		.rdata (code_rbits)
	);

	pcsm_ram #(
		.WIDTH(32),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rd)
	);

	pcsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

// File: dv/tb_pcode_stack_machine.sv
// Testbench for the p-code stack machine: directed and random programs checked against a predictor.
`timescale 1ns / 1ps

module tb_pcode_stack_machine;
	import pcsm_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	in_item_t  req;
	logic      rsp_valid;
	logic      rsp_stall;
	out_item_t rsp;

	pcode_stack_machine DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Machine state mirror, with written flags so generated programs read only written entries
	code_word_t  prog [512];
	bit          prog_ok [512];
	logic [31:0] stk [1024];
	bit          stk_ok [1024];
	logic [8:0]  m_pc;
	logic [9:0]  m_fb;
	logic [9:0]  m_top;
	bit          m_halt;

	out_item_t   pending_results [$];
	int          errors;
	int          sent;
	int          hold_cycles;
	bit          bursty;
	int          burst_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h (time %0t)", what, got, want, $time);
		errors++;
	endtask

	function automatic void put(input logic [9:0] a, input logic [31:0] v);
		stk[a] = v;
		stk_ok[a] = 1'b1;
	endfunction

	// Static-link walk from the current frame
	function automatic logic [9:0] link_base(input logic [2:0] lev);
		logic [9:0] b;
		b = m_fb;
		for (int i = 0; i < lev; i++)
			b = stk[b][9:0];
		return b;
	endfunction

	function automatic bit link_ok(input logic [2:0] lev);
		logic [9:0] b;
		b = m_fb;
		for (int i = 0; i < lev; i++) begin
			if (!stk_ok[b])
				return 1'b0;
			b = stk[b][9:0];
		end
		return 1'b1;
	endfunction

	// True when executing w reads only written stack entries
	function automatic bit reads_written(input code_word_t w);
		logic [9:0] up, dn, rb2, rb3, a;
		up = m_top + 10'd1;
		dn = m_top - 10'd1;
		rb2 = m_fb + 10'd1;
		rb3 = m_fb + 10'd2;
		case (w.op)
			OP_OPR: begin
				if (w.arg[31:5] != 0)
					return 1'b1;
				case (w.arg[4:0])
					OPR_RET: return stk_ok[rb2] && stk_ok[rb3];
					OPR_NEG, OPR_ODD, OPR_PRINT, OPR_REAL: return stk_ok[m_top];
					OPR_OR: return stk_ok[m_top] && stk_ok[up];
					OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_EQ, OPR_NE,
					OPR_LT, OPR_GE, OPR_GT, OPR_LE: return stk_ok[m_top] && stk_ok[dn];
					default: return 1'b1;
				endcase
			end
			OP_LOD, OP_WRITE: begin
				if (!link_ok(w.lev))
					return 1'b0;
				a = link_base(w.lev) + w.arg[9:0];
				return stk_ok[a];
			end
			OP_STO: return link_ok(w.lev) && stk_ok[m_top];
			OP_CAL, OP_READ: return link_ok(w.lev);
			OP_JPC: return stk_ok[m_top];
			default: return 1'b1;
		endcase
	endfunction

	// Operator group of opr
	function automatic void run_operator(input logic [31:0] opn, inout out_item_t o);
		logic [9:0] t, dn, up, a;
		int x, y;
		logic [31:0] r;
		t = m_top;
		dn = t - 10'd1;
		up = t + 10'd1;
		x = stk[dn];
		y = stk[t];
		if (opn[31:5] != 0)
			return;
		case (opn[4:0])
			OPR_RET: begin
				m_top = m_fb - 10'd1;
				a = m_top + 10'd3;
				m_pc = stk[a][8:0];
				a = m_top + 10'd2;
				m_fb = stk[a][9:0];
				return;
			end
			OPR_NEG: begin put(t, -stk[t]); return; end
			OPR_ODD: begin put(t, {31'd0, stk[t][0]}); return; end
			OPR_NL: begin o.event_res = EV_NEWLINE; return; end
			OPR_PRINT, OPR_REAL: begin
				o.event_res = (opn[4:0] == OPR_PRINT) ? EV_PRINT : EV_REAL;
				o.value = stk[t];
				m_top = dn;
				return;
			end
			OPR_OR: begin
				put(t, {31'd0, (stk[t] != 0) || (stk[up] != 0)});
				m_top = dn;
				return;
			end
			OPR_ADD: r = stk[dn] + stk[t];
			OPR_SUB: r = stk[dn] - stk[t];
			OPR_MUL: r = stk[dn] * stk[t];
			OPR_DIV: begin
				if (y == 0) begin
					r = '0;
					o.event_res = EV_ERROR;
				end else if (x == 32'sh8000_0000 && y == -1) begin
					r = x;
				end else begin
					r = x / y;
				end
			end
			OPR_EQ: r = 32'(x == y);
			OPR_NE: r = 32'(x != y);
			OPR_LT: r = 32'(x < y);
			OPR_GE: r = 32'(x >= y);
			OPR_GT: r = 32'(x > y);
			OPR_LE: r = 32'(x <= y);
			default: return;
		endcase
		m_top = dn;
		put(dn, r);
	endfunction

	// Expected result of one accepted transfer; updates the mirror
	function automatic out_item_t machine_step(input in_item_t it);
		out_item_t o;
		code_word_t w;
		logic [9:0] a, lb;
		o = '0;
		case (it.command)
			CMD_LOAD: begin
				prog[it.code_addr] = '{op: it.instr_op, lev: it.instr_level, arg: it.instr_arg};
				prog_ok[it.code_addr] = 1'b1;
			end
			CMD_START: begin
				m_top = '0;
				m_fb = 10'd1;
				m_pc = '0;
				put(10'd1, '0);
				put(10'd2, '0);
				put(10'd3, '0);
				m_halt = 1'b0;
			end
			CMD_EXEC: begin
				if (m_halt) begin
					o.event_res = EV_HALTED;
				end else begin
					w = prog[m_pc];
					m_pc = m_pc + 9'd1;
					a = link_base(w.lev) + w.arg[9:0];
					case (w.op)
						OP_LIT: begin m_top = m_top + 10'd1; put(m_top, w.arg); end
						OP_OPR: run_operator(w.arg, o);
						OP_LOD: begin m_top = m_top + 10'd1; put(m_top, stk[a]); end
						OP_STO: begin
							put(a, stk[m_top]);
							o.event_res = EV_STORE;
							o.value = stk[m_top];
							m_top = m_top - 10'd1;
						end
						OP_CAL: begin
							lb = link_base(w.lev);
							put(m_top + 10'd1, {22'd0, lb});
							put(m_top + 10'd2, {22'd0, m_fb});
							put(m_top + 10'd3, {23'd0, m_pc});
							m_fb = m_top + 10'd1;
							m_pc = w.arg[8:0];
						end
						OP_INT: m_top = m_top + w.arg[9:0];
						OP_JMP: m_pc = w.arg[8:0];
						OP_JPC: if (stk[m_top] == 0) m_pc = w.arg[8:0];
						OP_READ: put(a, it.read_value);
						OP_WRITE: begin o.event_res = EV_WRITE; o.value = stk[a]; end
						default: ;
					endcase
					if (m_pc == 0) begin
						m_halt = 1'b1;
						if (o.event_res == EV_NONE)
							o.event_res = EV_HALTED;
					end
				end
			end
			default: ;
		endcase
		o.pc = m_pc;
		return o;
	endfunction

	// One transfer on the request side, with burst pacing
	task automatic send_item(input in_item_t it);
		int gap;
		if (bursty && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (req_stall !== 1'b0);
		pending_results.push_back(machine_step(it));
		sent++;
	endtask

	function automatic in_item_t make_item(input logic [1:0] cmd, input logic [8:0] addr,
			input code_word_t w);
		in_item_t it;
		it.command = cmd;
		it.code_addr = addr;
		it.instr_op = w.op;
		it.instr_level = w.lev;
		it.instr_arg = w.arg;
		it.read_value = $urandom;
		return it;
	endfunction

	function automatic code_word_t random_word();
		code_word_t w;
		w.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
		w.lev = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
		case (w.op)
			OP_LIT: w.arg = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 9) - 4;
			OP_OPR: w.arg = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 18);
			OP_INT: w.arg = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5);
			OP_CAL, OP_JMP, OP_JPC:
				w.arg = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 24);
			default: w.arg = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7);
		endcase
		return w;
	endfunction

	// Place w at the program counter and execute it
	task automatic run_word(input code_word_t w);
		send_item(make_item(CMD_LOAD, m_pc, w));
		send_item(make_item(CMD_EXEC, 9'($urandom), random_word()));
	endtask

	// One random step: mostly well-formed execution, some loads, starts and noise
	task automatic random_step();
		int r;
		code_word_t w;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			send_item(make_item(CMD_START, 9'($urandom), random_word()));
		end else if (r < 5) begin
			send_item(make_item(2'd3, 9'($urandom), random_word()));
		end else if (r < 10) begin
			send_item(make_item(CMD_LOAD, 9'($urandom), random_word()));
		end else if (m_halt) begin
			send_item(make_item($urandom_range(0, 2) ? CMD_START : CMD_EXEC, 9'($urandom),
				random_word()));
		end else begin
			if (!prog_ok[m_pc] || !reads_written(prog[m_pc])) begin
				w = random_word();
				for (int i = 0; i < 8 && !reads_written(w); i++)
					w = random_word();
				if (!reads_written(w))
					w = '{op: OP_LIT, lev: 3'd0, arg: $urandom};
				send_item(make_item(CMD_LOAD, m_pc, w));
			end
			send_item(make_item(CMD_EXEC, 9'($urandom), random_word()));
		end
	endtask

	task automatic test_halted_and_load_extremes();
		send_item(make_item(CMD_EXEC, 9'd0, random_word()));
		send_item(make_item(CMD_LOAD, 9'd511, '{op: OP_WRITE, lev: 3'd7, arg: 32'h7fff_ffff}));
		send_item(make_item(CMD_LOAD, 9'd0, '{op: OP_LIT, lev: 3'd0, arg: 32'h8000_0000}));
	endtask

	task automatic test_directed_program();
		send_item(make_item(CMD_START, 9'd0, random_word()));
		run_word('{op: OP_LIT, lev: 3'd0, arg: 32'h8000_0000});
		run_word('{op: OP_LIT, lev: 3'd0, arg: 32'hffff_ffff});
		// most negative over minus one wraps to itself
		run_word('{op: OP_OPR, lev: 3'd0, arg: {27'd0, OPR_DIV}});
		run_word('{op: OP_LIT, lev: 3'd0, arg: 32'd0});
		// divide by zero: error event, top becomes zero
		run_word('{op: OP_OPR, lev: 3'd0, arg: {27'd0, OPR_DIV}});
		run_word('{op: OP_OPR, lev: 3'd0, arg: {27'd0, OPR_PRINT}});
		// jump to zero halts, then execute reports halted
		run_word('{op: OP_JMP, lev: 3'd0, arg: 32'd0});
		send_item(make_item(CMD_EXEC, 9'd0, random_word()));
	endtask

	task automatic test_random_programs();
		bursty = 1'b1;
		while (sent < 1800)
			random_step();
	endtask

	task automatic test_output_backpressure();
		bursty = 1'b0;
		hold_cycles = 300;
		repeat (40) random_step();
		bursty = 1'b1;
	endtask

	// Receiver stall pattern, with a long hold when requested
	initial begin
		int mode, mode_left;
		mode = 0;
		mode_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				hold_cycles--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 128);
				end
				mode_left--;
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					default: rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", rsp.value, '0);
			end else begin
				want = pending_results.pop_front();
				if (rsp.event_res !== want.event_res)
					report("event", 32'(rsp.event_res), 32'(want.event_res));
				if (rsp.value !== want.value)
					report("value", rsp.value, want.value);
				if (rsp.pc !== want.pc)
					report("pc", 32'(rsp.pc), 32'(want.pc));
			end
		end
	end

	initial begin
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		errors = 0;
		sent = 0;
		hold_cycles = 0;
		bursty = 1'b0;
		burst_left = 0;
		m_pc = '0;
		m_fb = 10'd1;
		m_top = '0;
		m_halt = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_halted_and_load_extremes();
		test_directed_program();
		test_output_backpressure();
		test_random_programs();

		@(negedge clk);
		req_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/pcsm_pkg.sv
hw/rtl/pcsm_ram.sv
hw/rtl/pcsm_div.sv
hw/rtl/pcode_stack_machine.sv
dv/tb_pcode_stack_machine.sv
